// ===== rtl/core/sync_length_sum_frame_receiver_top_assert.svh =====
// assertion macros for the frame receiver checker
`ifndef SYNC_LENGTH_SUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_LENGTH_SUM_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define SLSFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define SLSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slsfr_pkg.sv =====
package slsfr_pkg;

    // sync pattern
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // body positions of the captured bytes
    localparam logic [8:0] POS_DATA_LOW  = 9'd2;
    localparam logic [8:0] POS_DATA_HIGH = 9'd3;
    localparam logic [8:0] POS_COMMAND   = 9'd4;
    localparam logic [8:0] POS_SUB_CMD   = 9'd5;

    // length limits
    localparam logic [7:0] MIN_GOOD_LENGTH = 8'd4;
    localparam logic [7:0] MIN_SUB_LENGTH  = 8'd5;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SYNC2  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_TOO_SHORT = 2'd2
    } t_frame_status;

    typedef struct packed {
        t_frame_status status;
        logic [7:0]    length;
        logic [7:0]    command;
        logic [15:0]   data;
        logic [7:0]    sub_command;
        logic [7:0]    computed_sum;
        logic [7:0]    received_sum;
    } t_result;

endpackage

// ===== rtl/core/slsfr_parser.sv =====
module slsfr_parser
    import slsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_done,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [8:0] r_count, n_count;
    logic [7:0] r_length, n_length;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_low, n_low;
    logic [7:0] r_high, n_high;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_sub, n_sub;

    logic [8:0] pos;
    logic [7:0] last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // captured frame bytes, cleared by the length byte before use
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_length <= n_length;
            r_sum    <= n_sum;
            r_low    <= n_low;
            r_high   <= n_high;
            r_cmd    <= n_cmd;
            r_sub    <= n_sub;
        end
    end

    // next state and frame end
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_length = r_length;
        n_sum    = r_sum;
        n_low    = r_low;
        n_high   = r_high;
        n_cmd    = r_cmd;
        n_sub    = r_sub;
        o_done   = 1'b0;
        pos      = r_count + 9'd1;
        // zero length acts as one body byte
        last     = (r_length == 8'd0) ? 8'd1 : r_length;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                n_phase = (i_byte == SYNC_SECOND) ? PH_LENGTH : PH_HUNT;
                n_count = '0;
            end
            PH_LENGTH: begin
                n_length = i_byte;
                n_sum    = i_byte;
                n_count  = '0;
                n_low    = '0;
                n_high   = '0;
                n_cmd    = '0;
                n_sub    = '0;
                n_phase  = PH_BODY;
            end
            PH_BODY: begin
                n_count = pos;
                if (pos == POS_DATA_LOW) begin
                    n_low = i_byte;
                end else if (pos == POS_DATA_HIGH) begin
                    n_high = i_byte;
                end else if (pos == POS_COMMAND) begin
                    n_cmd = i_byte;
                end else if (pos == POS_SUB_CMD) begin
                    n_sub = i_byte;
                end
                if (pos < {1'b0, last}) begin
                    n_sum = r_sum + i_byte;
                end else begin
                    o_done  = 1'b1;
                    n_phase = PH_HUNT;
                    n_count = '0;
                end
            end
        endcase
    end

    // result of the frame that this byte ends
    always_comb begin
        if (r_sum != i_byte) begin
            o_result.status = ST_BAD_SUM;
        end else if (r_length < MIN_GOOD_LENGTH) begin
            o_result.status = ST_TOO_SHORT;
        end else begin
            o_result.status = ST_GOOD;
        end
        o_result.length       = r_length;
        o_result.command      = n_cmd;
        o_result.data         = {n_high, n_low};
        o_result.sub_command  = (r_length >= MIN_SUB_LENGTH) ? n_sub : 8'd0;
        o_result.computed_sum = r_sum;
        o_result.received_sum = i_byte;
    end

endmodule

// ===== rtl/core/sync_length_sum_frame_receiver_top.sv =====
// sync / length / sum-8 frame receiver
//
// input channel: one received byte per item on i_byte_in, handshake
// i_in_valid / o_in_ready. the block hunts for 0xFF 0x55, takes a length
// byte L and then max(L,1) body bytes, the last of which is the checksum.
// output channel: one result item per finished frame, handshake
// o_out_valid / i_out_ready, with status, length, command, data word,
// sub-command, computed and received checksum.
//
// timing: a byte is taken into an input register at the edge that accepts
// it, decoded by the frame state machine in the following cycle, and the
// result of a frame-ending byte is loaded into the result register at the
// next edge on which that register is free.
// one byte per cycle is sustained while no frame-ending byte waits for the
// result register; the only loop is the state machine update.
//
// stall: a byte that ends no frame moves on even while a result waits;
// a frame-ending byte holds in the input register until the result
// register is free, and o_in_ready stays low meanwhile.
// reset: synchronous active low, returns to sync hunting with both
// registers empty; no clearing pass is needed.
module sync_length_sum_frame_receiver_top
    import slsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_length,
    output logic [7:0]  o_command_code,
    output logic [15:0] o_data_word,
    output logic [7:0]  o_sub_command,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       frame_done;
    t_result    frame_result;
    logic       out_free;
    logic       advance;

    // input item moves on unless it needs a busy result register
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !frame_done);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    slsfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_done   (frame_done),
        .o_result (frame_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && frame_done) begin
            r_out <= frame_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out.status;
    assign o_frame_length = r_out.length;
    assign o_command_code = r_out.command;
    assign o_data_word    = r_out.data;
    assign o_sub_command  = r_out.sub_command;
    assign o_computed_sum = r_out.computed_sum;
    assign o_received_sum = r_out.received_sum;

endmodule

// ===== rtl/core/slsfr_checker.sv =====
`include "sync_length_sum_frame_receiver_top_assert.svh"

module slsfr_checker
    import slsfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_frame_status,
    input logic [7:0]  o_frame_length,
    input logic [7:0]  o_command_code,
    input logic [15:0] o_data_word,
    input logic [7:0]  o_sub_command,
    input logic [7:0]  o_computed_sum,
    input logic [7:0]  o_received_sum
);

    logic        out_stall;
    logic [57:0] out_fields;
    logic        sum_claimed;
    logic        short_claimed;
    logic        short_ok;

    // result channel state seen on the ports
    assign out_stall     = o_out_valid && !i_out_ready;
    assign out_fields    = {o_frame_status, o_frame_length, o_command_code, o_data_word,
                            o_sub_command, o_computed_sum, o_received_sum};
    assign sum_claimed   = o_out_valid && (o_frame_status != ST_BAD_SUM);
    assign short_claimed = o_out_valid && (o_frame_status == ST_TOO_SHORT);
    assign short_ok      = (o_frame_length < MIN_GOOD_LENGTH) && (o_sub_command == 8'd0);

    // a stalled result item stays offered
    `SLSFR_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid, "result dropped while stalled")

    // a stalled result item keeps all its fields
    `SLSFR_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_fields), "result changed while stalled")

    // only a mismatch status may carry differing checksums
    `SLSFR_ASSERT_NOW(a_sum_status, sum_claimed, o_computed_sum == o_received_sum, "status vs sums")

    // too-short status only for short frames, and no sub-command then
    `SLSFR_ASSERT_NOW(a_short_len, short_claimed, short_ok, "too-short status on a long frame")

    // input stalls only behind a waiting result
    `SLSFR_ASSERT_NOW(a_in_stall, !o_in_ready, out_stall, "input stalled without a waiting result")

endmodule

bind sync_length_sum_frame_receiver_top slsfr_checker u_slsfr_checker (.*);

// ===== sim/tb_sync_length_sum_frame_receiver_top.sv =====
`timescale 1ns / 100ps

module tb_sync_length_sum_frame_receiver_top
    import slsfr_pkg::*;
();

    localparam int RESET_CYCLES = 7;
    localparam int STREAM_BYTES = 1750;
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_BIG      = 3;

    // result sink behaviors
    localparam int SINK_ALWAYS  = 0;
    localparam int SINK_RANDOM  = 1;
    localparam int SINK_PATTERN = 2;
    localparam int SINK_SLOW    = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_in = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_frame_length;
    logic [7:0]  o_command_code;
    logic [15:0] o_data_word;
    logic [7:0]  o_sub_command;
    logic [7:0]  o_computed_sum;
    logic [7:0]  o_received_sum;

    sync_length_sum_frame_receiver_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length),
        .o_command_code (o_command_code),
        .o_data_word    (o_data_word),
        .o_sub_command  (o_sub_command),
        .o_computed_sum (o_computed_sum),
        .o_received_sum (o_received_sum)
    );

    // serial bytes waiting to be sent, and frames expected back, oldest first
    logic [7:0] serial_q[$];
    t_result    frame_q[$];
    int         bytes_queued = 0;

    // deframer state, mirrors the block after reset
    t_phase     df_phase = PH_HUNT;
    logic [7:0] df_length = 8'h00;
    logic [8:0] df_count = 9'h000;
    logic [7:0] df_sum = 8'h00;
    logic [7:0] df_data_low = 8'h00;
    logic [7:0] df_data_high = 8'h00;
    logic [7:0] df_command = 8'h00;
    logic [7:0] df_sub = 8'h00;

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int sink_cycle = 0;
    int sink_mode = SINK_ALWAYS;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance the deframer by one accepted byte, queue a frame when one ends
    task automatic deframe_byte(input logic [7:0] b);
        t_result    frame;
        logic [8:0] last_pos;
        logic [8:0] pos;
        case (df_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) df_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                df_phase = (b == SYNC_SECOND) ? PH_LENGTH : PH_HUNT;
                df_count = '0;
            end
            PH_LENGTH: begin
                df_length    = b;
                df_sum       = b;
                df_count     = '0;
                df_data_low  = '0;
                df_data_high = '0;
                df_command   = '0;
                df_sub       = '0;
                df_phase     = PH_BODY;
            end
            default: begin
                last_pos = (df_length == 8'd0) ? 9'd1 : {1'b0, df_length};
                pos      = df_count + 9'd1;
                df_count = pos;
                if (pos == POS_DATA_LOW) df_data_low = b;
                else if (pos == POS_DATA_HIGH) df_data_high = b;
                else if (pos == POS_COMMAND) df_command = b;
                else if (pos == POS_SUB_CMD) df_sub = b;
                if (pos < last_pos) begin
                    df_sum = df_sum + b;
                end else begin
                    if (df_sum != b) frame.status = ST_BAD_SUM;
                    else if (df_length < MIN_GOOD_LENGTH) frame.status = ST_TOO_SHORT;
                    else frame.status = ST_GOOD;
                    frame.length       = df_length;
                    frame.command      = df_command;
                    frame.data         = {df_data_high, df_data_low};
                    frame.sub_command  = (df_length >= MIN_SUB_LENGTH) ? df_sub : 8'h00;
                    frame.computed_sum = df_sum;
                    frame.received_sum = b;
                    frame_q.push_back(frame);
                    df_phase = PH_HUNT;
                    df_count = '0;
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b);
        serial_q.push_back(b);
        bytes_queued++;
    endtask

    // sync, length, body; body bytes before the checksum random or all equal to fill
    task automatic push_frame(input logic [7:0] len, input bit good_sum,
                              input bit fixed, input logic [7:0] fill);
        int         body_count;
        logic [7:0] sum;
        logic [7:0] b;
        body_count = (len == 8'd0) ? 1 : int'(len);
        sum = len;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(len);
        for (int i = 1; i < body_count; i++) begin
            b = fixed ? fill : 8'($urandom);
            sum = sum + b;
            push_byte(b);
        end
        push_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic check_field(input string name, input logic [15:0] expected,
                               input logic [15:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
        end
    endtask

    // byte driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) deframe_byte(i_byte_in);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (serial_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_byte_in  <= serial_q.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink: one long hold-off, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        sink_cycle++;
        if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_CYCLES) begin
            i_out_ready <= 1'b0;
        end else begin
            if (sink_cycle % 128 == 0) sink_mode = $urandom_range(SINK_ALWAYS, SINK_SLOW);
            case (sink_mode)
                SINK_ALWAYS:  i_out_ready <= 1'b1;
                SINK_RANDOM:  i_out_ready <= 1'($urandom_range(0, 1));
                SINK_PATTERN: i_out_ready <= (sink_cycle % 4) != 0;
                default:      i_out_ready <= (sink_cycle % 5) == 0;
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result expected_frame;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                $error("unexpected result item: status %0d length %0d received_sum 0x%0h",
                       o_frame_status, o_frame_length, o_received_sum);
                error_count++;
            end else begin
                expected_frame = frame_q.pop_front();
                check_field("frame_status", 16'(expected_frame.status), 16'(o_frame_status));
                check_field("frame_length", 16'(expected_frame.length), 16'(o_frame_length));
                check_field("command_code", 16'(expected_frame.command), 16'(o_command_code));
                check_field("data_word", expected_frame.data, o_data_word);
                check_field("sub_command", 16'(expected_frame.sub_command),
                            16'(o_sub_command));
                check_field("computed_sum", 16'(expected_frame.computed_sum),
                            16'(o_computed_sum));
                check_field("received_sum", 16'(expected_frame.received_sum),
                            16'(o_received_sum));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sync_length_sum_frame_receiver_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int         pick;
        int         sel;
        int         big_count;
        int         cut_len;
        logic [7:0] len;
        logic [7:0] b;
        big_count = 0;

        // noise while hunting, including a lone second sync byte
        push_byte(8'h00);
        push_byte(SYNC_SECOND);
        // broken sync
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        // a repeated first sync byte drops back to hunting
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        // zero length acts as one body byte
        push_frame(8'd0, 1'b1, 1'b0, 8'h00);
        push_frame(8'd0, 1'b0, 1'b0, 8'h00);
        // short frames, checksum fills the captured positions
        push_frame(8'd1, 1'b1, 1'b0, 8'h00);
        push_frame(8'd2, 1'b1, 1'b0, 8'h00);
        push_frame(8'd3, 1'b0, 1'b0, 8'h00);
        push_frame(8'd3, 1'b1, 1'b0, 8'h00);
        push_frame(8'd4, 1'b1, 1'b0, 8'h00);
        push_frame(8'd4, 1'b0, 1'b0, 8'h00);
        push_frame(8'd5, 1'b1, 1'b0, 8'h00);
        push_frame(8'd6, 1'b1, 1'b0, 8'h00);
        // extremes of the body bytes
        push_frame(8'd6, 1'b1, 1'b1, 8'hFF);
        push_frame(8'd7, 1'b1, 1'b1, 8'h00);

        // random part: mostly well-formed frames, some noise and broken ones
        while (bytes_queued < STREAM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    len = 8'($urandom_range(0, 8));
                end else if (sel < 98 || big_count >= MAX_BIG) begin
                    len = 8'($urandom_range(9, 40));
                end else begin
                    len = (big_count == 0) ? 8'd255 : 8'($urandom_range(200, 255));
                    big_count++;
                end
                push_frame(len, $urandom_range(0, 3) != 0, 1'b0, 8'h00);
            end else if (pick < 82) begin
                push_byte(8'($urandom));
            end else if (pick < 92) begin
                push_byte(SYNC_FIRST);
                b = 8'($urandom);
                if (b == SYNC_SECOND) b = SYNC_FIRST;
                push_byte(b);
            end else begin
                // frame cut short, the following bytes land in its body
                cut_len = $urandom_range(2, 20);
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                push_byte(8'(cut_len));
                repeat ($urandom_range(0, cut_len - 1)) push_byte(8'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain the stream and all expected frames
        while (serial_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sync_length_sum_frame_receiver_top regression: pass");
        end else begin
            $display("sync_length_sum_frame_receiver_top regression: fail");
        end
        $finish;
    end

endmodule
